// ===== src/top_k_ratio_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// top_k_ratio_tracker_core_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef TOP_K_RATIO_TRACKER_CORE_DEFINES_SVH
`define TOP_K_RATIO_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TKRT_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define TKRT_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/tkrt_pkg.sv =====
// ----------------------------------------------------------------------------
// tkrt_pkg
// types and constants of the top-k ratio tracker
// ----------------------------------------------------------------------------
package tkrt_pkg;

    localparam int NUM_W = 36;
    localparam int DEN_W = 24;
    localparam int CNT_W = 6;

    localparam logic [1:0] CMD_OFFER = 2'd0;
    localparam logic [1:0] CMD_DUMP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] MODE_SPEED = 3'd0;
    localparam logic [2:0] MODE_TIME  = 3'd1;
    localparam logic [2:0] MODE_VC    = 3'd2;
    localparam logic [2:0] MODE_TCHG  = 3'd3;
    localparam logic [2:0] MODE_VCHG  = 3'd4;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_MINVOL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_PREP,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE,
        ST_RESULT,
        ST_DUMP_RD,
        ST_DUMP_CMP
    } state_t;

    typedef enum logic [1:0] {
        PH_BASE,
        PH_LOAD,
        PH_RATIO
    } phase_t;

    typedef struct packed {
        logic [23:0]        link;
        logic [23:0]        src_node;
        logic [23:0]        dst_node;
        logic [9:0]         period;
        logic [23:0]        base;
        logic [23:0]        load;
        logic signed [31:0] ratio;
    } entry_t;

    typedef struct packed {
        logic               accepted;
        logic [5:0]         slot;
        logic               entry_valid;
        logic [23:0]        link;
        logic [23:0]        src_node;
        logic [23:0]        dst_node;
        logic [9:0]         period;
        logic [23:0]        base;
        logic [23:0]        load;
        logic signed [31:0] ratio;
        logic               last;
    } result_t;

endpackage

// ===== src/tkrt_div.sv =====
// ----------------------------------------------------------------------------
// tkrt_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tkrt_div
    import tkrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== src/tkrt_mem.sv =====
// ----------------------------------------------------------------------------
// tkrt_mem
// list storage: one write port, one registered read port, per-entry valid
// ----------------------------------------------------------------------------
module tkrt_mem
    import tkrt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t             ram [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rd_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= valid_reg[raddr] & ~clr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= ram[raddr];
        end
    end

    // an entry never written reads as empty
    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

// ===== src/top_k_ratio_tracker_core.sv =====
// ----------------------------------------------------------------------------
// top_k_ratio_tracker_core
// keeps the K highest per-mille ratios of offered records in sorted order
// ----------------------------------------------------------------------------
// usage:
//   input beats (in_valid/in_stall) carry a command: offer a record, dump the
//   list or clear it. result beats (out_valid/out_stall) come from an output
//   register; an offer, a clear or an empty dump gives one beat, a dump gives
//   one beat per present entry with last_entry on the final one.
//   one item is worked on at a time; in_stall is high until its last result
//   beat has been loaded into the output register.
//   offer: one divide for the ratio (speed mode runs three, for base, load and
//   ratio), then a read and a compare per list entry scanned and a read and a
//   write per entry shifted down. dump: a read per entry, and it waits while
//   the receiver stalls. all divides share the one serial divider.
//   reset empties the list at once through per-entry valid bits, clears the
//   running minimum and both registers. a stalled result beat holds; the
//   block keeps working until it needs the output register again.
// ----------------------------------------------------------------------------
module top_k_ratio_tracker_core
    import tkrt_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [23:0]        link_id,
    input  logic [23:0]        from_node,
    input  logic [23:0]        to_node,
    input  logic [9:0]         period,
    input  logic [19:0]        length,
    input  logic [19:0]        free_time,
    input  logic [19:0]        loaded_time,
    input  logic [19:0]        prior_time,
    input  logic [19:0]        volume,
    input  logic [19:0]        prior_volume,
    input  logic [19:0]        capacity,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic [5:0]         slot,
    output logic               entry_valid,
    output logic [23:0]        out_link,
    output logic [23:0]        out_from,
    output logic [23:0]        out_to,
    output logic [9:0]         out_period,
    output logic [23:0]        out_base,
    output logic [23:0]        out_load,
    output logic signed [31:0] out_ratio,
    output logic               last_entry
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] LAST_C  = IW'(LIST_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_C = IW'(LIST_DEPTH);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [2:0]  mode_reg;
    logic [19:0] minvol_reg;

    logic [1:0]  cmd_reg;
    logic [23:0] link_reg, from_reg, to_reg;
    logic [9:0]  period_reg;
    logic [19:0] len_reg, t0_reg, tl_reg, tp_reg, vol_reg, pvol_reg, cap_reg;

    logic [23:0]        base_reg, load_reg;
    logic               neg_reg;
    logic signed [31:0] ratio_reg;
    logic signed [31:0] min_reg;
    logic               ev_reg, acc_reg;
    logic [IW-1:0]      idx_reg, slot_reg;
    entry_t             pend_reg;

    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    emit;
    result_t emit_res;

    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;

    logic          mem_clr, mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;

    logic               skip;
    logic [23:0]        len10;
    logic               use_diff;
    logic signed [25:0] diff;
    logic signed [36:0] num_s;
    logic [NUM_W-1:0]   num_mag;
    logic signed [31:0] ratio_sat;
    logic [IW-1:0]      idx_dec;
    entry_t             new_entry;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SPEED;
            minvol_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_MODE:   mode_reg   <= pwdata[2:0];
                REG_MINVOL: minvol_reg <= pwdata[19:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODE:   prdata = {29'b0, mode_reg};
            REG_MINVOL: prdata = {12'b0, minvol_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    always_comb
    begin
        skip = (vol_reg < minvol_reg) || (t0_reg == '0);
        case (mode_reg)
            MODE_SPEED: skip = skip || (tl_reg == '0);
            MODE_TIME:  skip = skip;
            MODE_VC:    skip = skip || (cap_reg == '0);
            MODE_TCHG:  skip = skip || (pvol_reg < minvol_reg) || (tp_reg == '0);
            MODE_VCHG:  skip = skip || (pvol_reg < minvol_reg) || (pvol_reg == '0);
            default:    skip = 1'b1;
        endcase
    end

    assign len10    = 24'({len_reg, 3'b0}) + 24'({len_reg, 1'b0});
    assign use_diff = (mode_reg == MODE_SPEED) || (mode_reg == MODE_TCHG) ||
                      (mode_reg == MODE_VCHG);
    // speed mode measures the drop from base, the change modes the rise over base
    assign diff     = (mode_reg == MODE_SPEED)
                    ? ($signed({2'b0, base_reg}) - $signed({2'b0, load_reg}))
                    : use_diff ? ($signed({2'b0, load_reg}) - $signed({2'b0, base_reg}))
                               : $signed({2'b0, load_reg});
    assign num_s    = 37'(diff) * 37'sd1000 + $signed({14'b0, base_reg[23:1]});
    assign num_mag  = num_s[36] ? NUM_W'(-num_s) : num_s[NUM_W-1:0];

    always_comb
    begin
        if (!neg_reg)
        begin
            ratio_sat = (|div_quo[NUM_W-1:31]) ? 32'sh7FFFFFFF : $signed(div_quo[31:0]);
        end
        else
        begin
            ratio_sat = (div_quo > NUM_W'(36'h080000000)) ? 32'sh80000000
                                                          : $signed(-div_quo[31:0]);
        end
    end

    assign idx_dec = idx_reg - 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        new_entry.link     = link_reg;
        new_entry.src_node = from_reg;
        new_entry.dst_node = to_reg;
        new_entry.period   = period_reg;
        new_entry.base     = base_reg;
        new_entry.load     = load_reg;
        new_entry.ratio    = ratio_reg;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        mem_clr    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg[AW-1:0];
        mem_wdata  = new_entry;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[AW-1:0];
        emit       = 1'b0;
        emit_res   = '0;
        emit_res.last = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg)
                    CMD_OFFER:
                    begin
                        if (skip)
                        begin
                            state_next = ST_RESULT;
                        end
                        else if (mode_reg == MODE_SPEED)
                        begin
                            div_start  = 1'b1;
                            div_num    = NUM_W'(len10 + 24'(t0_reg[19:1]));
                            div_den    = DEN_W'(t0_reg);
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_PREP;
                        end
                    end
                    CMD_DUMP:  state_next = ST_DUMP_RD;
                    CMD_CLEAR:
                    begin
                        mem_clr    = 1'b1;
                        state_next = ST_RESULT;
                    end
                    default:   state_next = ST_RESULT;
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_BASE:
                        begin
                            div_start = 1'b1;
                            div_num   = NUM_W'(len10 + 24'(tl_reg[19:1]));
                            div_den   = DEN_W'(tl_reg);
                        end
                        PH_LOAD:
                        begin
                            state_next = (base_reg == '0) ? ST_RESULT : ST_PREP;
                        end
                        default:  state_next = ST_CHECK;
                    endcase
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                div_num    = num_mag;
                div_den    = base_reg;
                state_next = ST_DIV;
            end
            ST_CHECK:
            begin
                state_next = (ratio_reg > min_reg) ? ST_SCAN_RD : ST_RESULT;
            end
            ST_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (ratio_reg > mem_rdata.ratio)
                begin
                    state_next = (mem_rdata.ratio > 0 && idx_reg != LAST_C) ? ST_SHIFT_RD
                                                                          : ST_WRITE;
                end
                else
                begin
                    state_next = (idx_reg == LAST_C) ? ST_RESULT : ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_dec[AW-1:0];
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                state_next = (idx_dec == slot_reg) ? ST_WRITE : ST_SHIFT_RD;
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                emit_res.accepted    = acc_reg;
                emit_res.slot        = acc_reg ? 6'(slot_reg) : 6'd0;
                emit_res.entry_valid = ev_reg;
                emit_res.base        = ev_reg ? base_reg : '0;
                emit_res.load        = ev_reg ? load_reg : '0;
                emit_res.ratio       = ev_reg ? ratio_reg : '0;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD:
            begin
                if (idx_reg == DEPTH_C)
                begin
                    emit_res.slot        = 6'(idx_dec);
                    emit_res.entry_valid = 1'b1;
                    emit_res.link        = pend_reg.link;
                    emit_res.src_node    = pend_reg.src_node;
                    emit_res.dst_node    = pend_reg.dst_node;
                    emit_res.period      = pend_reg.period;
                    emit_res.base        = pend_reg.base;
                    emit_res.load        = pend_reg.load;
                    emit_res.ratio       = pend_reg.ratio;
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_DUMP_CMP;
                end
            end
            ST_DUMP_CMP:
            begin
                // the entry one back goes out once we know whether it is the last
                if (idx_reg != '0)
                begin
                    emit_res.slot        = 6'(idx_dec);
                    emit_res.entry_valid = 1'b1;
                    emit_res.link        = pend_reg.link;
                    emit_res.src_node    = pend_reg.src_node;
                    emit_res.dst_node    = pend_reg.dst_node;
                    emit_res.period      = pend_reg.period;
                    emit_res.base        = pend_reg.base;
                    emit_res.load        = pend_reg.load;
                    emit_res.ratio       = pend_reg.ratio;
                    emit_res.last        = (mem_rdata.ratio == 0);
                end
                if (mem_rdata.ratio == 0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_DUMP_RD;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_DUMP_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BASE;
            min_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_DECODE:
                begin
                    phase_reg <= PH_BASE;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        min_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (div_done && phase_reg == PH_BASE)
                    begin
                        phase_reg <= PH_LOAD;
                    end
                end
                ST_PREP:     phase_reg <= PH_RATIO;
                ST_SHIFT_WR:
                begin
                    // the new tail is what sat one above it
                    if (idx_reg == LAST_C)
                    begin
                        min_reg <= mem_rdata.ratio;
                    end
                end
                default:     phase_reg <= phase_reg;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_res;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg    <= cmd;
                    link_reg   <= link_id;
                    from_reg   <= from_node;
                    to_reg     <= to_node;
                    period_reg <= period;
                    len_reg    <= length;
                    t0_reg     <= free_time;
                    tl_reg     <= loaded_time;
                    tp_reg     <= prior_time;
                    vol_reg    <= volume;
                    pvol_reg   <= prior_volume;
                    cap_reg    <= capacity;
                end
            end
            ST_DECODE:
            begin
                acc_reg <= 1'b0;
                ev_reg  <= 1'b0;
                idx_reg <= '0;
                case (mode_reg)
                    MODE_TIME:
                    begin
                        base_reg <= 24'(t0_reg);
                        load_reg <= 24'(tl_reg);
                    end
                    MODE_VC:
                    begin
                        base_reg <= 24'(cap_reg);
                        load_reg <= 24'(vol_reg);
                    end
                    MODE_TCHG:
                    begin
                        base_reg <= 24'(tp_reg);
                        load_reg <= 24'(tl_reg);
                    end
                    MODE_VCHG:
                    begin
                        base_reg <= 24'(pvol_reg);
                        load_reg <= 24'(vol_reg);
                    end
                    default:
                    begin
                        base_reg <= '0;
                        load_reg <= '0;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_BASE: base_reg <= div_quo[23:0];
                        PH_LOAD: load_reg <= div_quo[23:0];
                        default:
                        begin
                            ratio_reg <= ratio_sat;
                            ev_reg    <= 1'b1;
                        end
                    endcase
                end
            end
            ST_PREP:     neg_reg <= num_s[36];
            ST_CHECK:    idx_reg <= '0;
            ST_SCAN_CMP:
            begin
                if (ratio_reg > mem_rdata.ratio)
                begin
                    slot_reg <= idx_reg;
                    idx_reg  <= LAST_C;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_SHIFT_WR: idx_reg <= idx_dec;
            ST_WRITE:    acc_reg <= 1'b1;
            ST_DUMP_CMP:
            begin
                if (mem_rdata.ratio != 0 && (idx_reg == '0 || out_free))
                begin
                    pend_reg <= mem_rdata;
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
            default:     acc_reg <= acc_reg;
        endcase
    end

    // ---------------- units ----------------
    tkrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    tkrt_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_clr),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- result beat ----------------
    assign out_valid   = out_valid_reg;
    assign accepted    = out_reg.accepted;
    assign slot        = out_reg.slot;
    assign entry_valid = out_reg.entry_valid;
    assign out_link    = out_reg.link;
    assign out_from    = out_reg.src_node;
    assign out_to      = out_reg.dst_node;
    assign out_period  = out_reg.period;
    assign out_base    = out_reg.base;
    assign out_load    = out_reg.load;
    assign out_ratio   = out_reg.ratio;
    assign last_entry  = out_reg.last;

endmodule

// ===== src/tkrt_checker.sv =====
// ----------------------------------------------------------------------------
// tkrt_checker
// port-level checks on the tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "top_k_ratio_tracker_core_defines.svh"

module tkrt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               accepted,
    input logic               entry_valid,
    input logic               last_entry,
    input logic signed [31:0] out_ratio
);

    // a stalled result beat stays offered
    `TKRT_AST_NXT(a_out_hold, out_valid && out_stall, out_valid)

    // one item at a time: a taken input beat makes the block busy
    `TKRT_AST_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)

    // an insertion is a single, computed result
    `TKRT_AST_IMP(a_acc_valid, out_valid && accepted, entry_valid && last_entry)

    // skipped or empty results carry no ratio
    `TKRT_AST_IMP(a_skip_zero, out_valid && !entry_valid, out_ratio == 0 && !accepted)

endmodule

bind top_k_ratio_tracker_core tkrt_checker u_tkrt_checker (.*);
